@@ design/ipc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_pkg: shared definitions for the interrupt priority controller
// Sizes, memory map constants, item action codes and the scan unit's
// request and status bundles.
// ----------------------------------------------------------------------------
package ipc_pkg;

  // Sizes
  localparam int NUM_SRC   = 32;
  localparam int NUM_CTX   = 2;
  localparam int SRC_W     = $clog2(NUM_SRC);
  localparam int CTX_W     = (NUM_CTX > 1) ? $clog2(NUM_CTX) : 1;
  localparam int PRI_W     = 3;
  localparam int PRI_DEPTH = 32;
  localparam int PRI_AW    = 5;
  localparam int DATA_W    = 32;
  localparam int OFF_W     = 26;
  localparam int PEND_IW   = 5;

  // Memory map
  localparam logic [OFF_W-1:0] PRI_END    = 26'h000_1000;
  localparam logic [OFF_W-1:0] PRI_WR_MIN = 26'h000_0004;
  localparam logic [OFF_W-1:0] PEND_OFF   = 26'h000_1000;
  localparam logic [OFF_W-1:0] ENA_BASE   = 26'h000_2000;
  localparam logic [OFF_W-1:0] ENA_END    = 26'h000_2100;
  localparam int               ENA_SHIFT  = $clog2(32'h80);
  localparam logic [OFF_W-1:0] CTX_BASE   = 26'h020_0000;
  localparam int               CTX_SHIFT  = $clog2(32'h1000);
  localparam int               CTXN_W     = OFF_W - CTX_SHIFT;
  localparam logic [CTX_SHIFT-1:0] LOC_THR   = 12'h000;
  localparam logic [CTX_SHIFT-1:0] LOC_CLAIM = 12'h004;
  localparam logic [DATA_W-1:0]    ENA_MASK  = ~32'h1;

  // Item actions
  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_RAISE = 2'd2,
    ACT_LOWER = 2'd3
  } action_e;

  // Scan unit request (held steady by the sequencer during a scan)
  typedef struct packed {
    logic               start;
    logic [PRI_W-1:0]   threshold;
    logic [NUM_SRC-1:0] active;
  } scan_req_t;

  // Scan unit status
  typedef struct packed {
    logic             done;
    logic [SRC_W-1:0] best;
  } scan_sts_t;

endpackage

@@ design/ipc_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_scan: sequential best-source search
// Walks sources 1 to NUM_SRC-1, one priority read and one compare per
// cycle, keeping the lowest id whose priority is strictly highest above
// the threshold. Pulses done with the winner (0 when none).
// ----------------------------------------------------------------------------
module ipc_scan
  import ipc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  scan_req_t        req_i,
  output logic [SRC_W-1:0] pri_addr_o,
  input  logic [PRI_W-1:0] pri_data_i,
  output scan_sts_t        sts_o
);

  localparam logic [SRC_W-1:0] FIRST_ID = SRC_W'(1);
  localparam logic [SRC_W-1:0] LAST_ID  = SRC_W'(NUM_SRC - 1);

  logic             issue_q;
  logic [SRC_W-1:0] idx_q;
  logic             cmp_vld_q;
  logic             cmp_last_q;
  logic [SRC_W-1:0] cmp_idx_q;
  logic [PRI_W-1:0] level_q;
  logic [SRC_W-1:0] best_q;
  logic             done_q;
  logic             hit;

  // Compare stage: priority data arrives in the cycle after its address
  assign hit = cmp_vld_q && req_i.active[cmp_idx_q] && (pri_data_i > level_q);

  // Address issue, compare tracking and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q    <= 1'b0;
      idx_q      <= FIRST_ID;
      cmp_vld_q  <= 1'b0;
      cmp_last_q <= 1'b0;
      cmp_idx_q  <= '0;
      level_q    <= '0;
      best_q     <= '0;
      done_q     <= 1'b0;
    end else begin
      done_q <= cmp_vld_q && cmp_last_q;
      if (req_i.start) begin
        issue_q   <= 1'b1;
        idx_q     <= FIRST_ID;
        cmp_vld_q <= 1'b0;
        level_q   <= req_i.threshold;
        best_q    <= '0;
      end else begin
        cmp_vld_q <= issue_q;
        if (issue_q) begin
          cmp_idx_q  <= idx_q;
          cmp_last_q <= (idx_q == LAST_ID);
          if (idx_q == LAST_ID) begin
            issue_q <= 1'b0;
          end else begin
            idx_q <= idx_q + FIRST_ID;
          end
        end
        if (hit) begin
          level_q <= pri_data_i;
          best_q  <= cmp_idx_q;
        end
      end
    end
  end

  assign pri_addr_o = idx_q;
  assign sts_o.done = done_q;
  assign sts_o.best = best_q;

endmodule

@@ design/interrupt_priority_controller_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interrupt_priority_controller_core: platform interrupt controller
// 32 sources, machine and supervisor contexts, bus accesses and pending
// events handled one item at a time by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item: a bus read,
//   a bus write, or a raise or lower of a source's pending bit. Output
//   channel (out_valid_o / out_stall_i) returns exactly one result per
//   item: read data plus both interrupt lines as they stand after it.
//   in_stall_o is high from acceptance until the result is loaded into
//   the output register, so one item is in flight at a time.
//   Every item runs one source scan per context on the shared compare
//   unit and priority RAM port; a priority read adds the S_PRI_RD and
//   S_PRI_DATA states and a claim read adds one more scan. The next
//   item can be accepted in the cycle after the previous result loads.
//   A result waiting on a stalled receiver stays in the output register;
//   the next item is still accepted and held finished until it drains.
//   Reset clears priorities (per-entry valid bits), pending, enables and
//   thresholds at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module interrupt_priority_controller_core
  import ipc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        action_i,
  input  logic [OFF_W-1:0]  offset_i,
  input  logic [DATA_W-1:0] write_data_i,
  input  logic [4:0]        source_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DATA_W-1:0] read_data_o,
  output logic              machine_irq_o,
  output logic              supervisor_irq_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_PRI_RD,
    S_PRI_DATA,
    S_CLAIM_START,
    S_CLAIM_WAIT,
    S_IRQ0_START,
    S_IRQ0_WAIT,
    S_IRQ1_START,
    S_IRQ1_WAIT,
    S_OUT
  } state_e;

  state_e state_q;

  // Latched item
  action_e           act_q;
  logic [OFF_W-1:0]  off_q;
  logic [DATA_W-1:0] wdata_q;
  logic [4:0]        src_q;

  // Controller state
  logic [DATA_W-1:0] pending_q;
  logic [DATA_W-1:0] enable_q [NUM_CTX];
  logic [PRI_W-1:0]  thresh_q [NUM_CTX];

  // Result being built and output register
  logic [DATA_W-1:0] rdata_q;
  logic              irq0_q;
  logic              irq1_q;
  logic              out_vld_q;
  logic [DATA_W-1:0] out_rdata_q;
  logic              out_irq0_q;
  logic              out_irq1_q;

  logic [CTX_W-1:0]  scan_ctx_q;

  // Priority RAM with per-entry valid bits
  logic [PRI_W-1:0]  pri_mem [PRI_DEPTH];
  logic [PRI_DEPTH-1:0] pri_vld_q;
  logic [PRI_W-1:0]  pri_rdata_q;
  logic              pri_rvld_q;
  logic [PRI_W-1:0]  pri_rd;
  logic              pri_we;
  logic [PRI_AW-1:0] pri_waddr;
  logic [PRI_AW-1:0] pri_raddr;

  // Scan unit hookup
  scan_req_t         scan_req;
  scan_sts_t         scan_sts;
  logic [SRC_W-1:0]  scan_addr;
  logic [CTX_W-1:0]  scan_ctx;

  // Offset decode
  logic                 in_pri;
  logic                 in_pend;
  logic                 in_ena;
  logic [OFF_W-1:0]     ena_rel;
  logic [CTX_W-1:0]     ena_ctx;
  logic                 ena_ok;
  logic                 in_ctx;
  logic [OFF_W-1:0]     ctx_rel;
  logic [CTXN_W-1:0]    ctx_num;
  logic [CTX_W-1:0]     ctx_idx;
  logic                 ctx_ok;
  logic [CTX_SHIFT-1:0] ctx_loc;
  logic                 is_claim;
  logic                 src_ok;
  logic                 in_acc;
  logic                 out_free;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_vld_q || !out_stall_i;

  assign in_pri  = (off_q < PRI_END);
  assign in_pend = (off_q == PEND_OFF);
  assign in_ena  = (off_q >= ENA_BASE) && (off_q < ENA_END);
  assign ena_rel = off_q - ENA_BASE;
  assign ena_ctx = ena_rel[ENA_SHIFT +: CTX_W];
  assign ena_ok  = in_ena && (CTXN_W'(ena_rel >> ENA_SHIFT) < CTXN_W'(NUM_CTX));
  assign in_ctx  = (off_q >= CTX_BASE);
  assign ctx_rel = off_q - CTX_BASE;
  assign ctx_num = ctx_rel[OFF_W-1:CTX_SHIFT];
  assign ctx_idx = ctx_num[CTX_W-1:0];
  assign ctx_ok  = in_ctx && (ctx_num < CTXN_W'(NUM_CTX));
  assign ctx_loc = ctx_rel[CTX_SHIFT-1:0];
  assign is_claim = (act_q == ACT_READ) && ctx_ok && (ctx_loc == LOC_CLAIM);
  assign src_ok  = (src_q != 5'd0) && ({1'b0, src_q} < 6'(NUM_SRC));

  // Priority RAM port control
  assign pri_we    = (state_q == S_DECODE) && (act_q == ACT_WRITE) &&
                     (off_q >= PRI_WR_MIN) && in_pri;
  assign pri_waddr = off_q[PRI_AW+1:2];
  assign pri_raddr = (state_q == S_PRI_RD) ? off_q[PRI_AW+1:2] : PRI_AW'(scan_addr);
  assign pri_rd    = pri_rvld_q ? pri_rdata_q : '0;

  always_ff @(posedge clk_i) begin
    if (pri_we) begin
      pri_mem[pri_waddr] <= wdata_q[PRI_W-1:0];
    end
    pri_rdata_q <= pri_mem[pri_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pri_vld_q  <= '0;
      pri_rvld_q <= 1'b0;
    end else begin
      if (pri_we) begin
        pri_vld_q[pri_waddr] <= 1'b1;
      end
      pri_rvld_q <= pri_vld_q[pri_raddr];
    end
  end

  // IRQ start states load scan_ctx_q on the start edge, so pick the
  // context directly there; the threshold is sampled at start
  assign scan_ctx = (state_q == S_IRQ0_START) ? '0 :
                    (state_q == S_IRQ1_START) ? CTX_W'(NUM_CTX - 1) : scan_ctx_q;

  // Scan request for the selected context
  assign scan_req.start     = (state_q == S_CLAIM_START) || (state_q == S_IRQ0_START) ||
                              (state_q == S_IRQ1_START);
  assign scan_req.threshold = thresh_q[scan_ctx];
  assign scan_req.active    = pending_q[NUM_SRC-1:0] & enable_q[scan_ctx][NUM_SRC-1:0];

  ipc_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (scan_req),
    .pri_addr_o (scan_addr),
    .pri_data_i (pri_rd),
    .sts_o      (scan_sts)
  );

  // Sequencer, controller registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_q       <= ACT_READ;
      off_q       <= '0;
      wdata_q     <= '0;
      src_q       <= '0;
      pending_q   <= '0;
      for (int c = 0; c < NUM_CTX; c++) begin
        enable_q[c] <= '0;
        thresh_q[c] <= '0;
      end
      rdata_q     <= '0;
      irq0_q      <= 1'b0;
      irq1_q      <= 1'b0;
      scan_ctx_q  <= '0;
      out_vld_q   <= 1'b0;
      out_rdata_q <= '0;
      out_irq0_q  <= 1'b0;
      out_irq1_q  <= 1'b0;
    end else begin
      if (out_vld_q && !out_stall_i && (state_q != S_OUT)) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            act_q   <= action_e'(action_i);
            off_q   <= offset_i;
            wdata_q <= write_data_i;
            src_q   <= source_i;
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          rdata_q <= '0;
          state_q <= S_IRQ0_START;
          case (act_q)
            ACT_READ: begin
              if (in_pri) begin
                state_q <= S_PRI_RD;
              end else if (in_pend) begin
                rdata_q <= pending_q;
              end else if (ena_ok) begin
                rdata_q <= enable_q[ena_ctx];
              end else if (ctx_ok && (ctx_loc == LOC_THR)) begin
                rdata_q <= DATA_W'(thresh_q[ctx_idx]);
              end else if (is_claim) begin
                scan_ctx_q <= ctx_idx;
                state_q    <= S_CLAIM_START;
              end
            end
            ACT_WRITE: begin
              if (ena_ok) begin
                enable_q[ena_ctx] <= wdata_q & ENA_MASK;
              end else if (ctx_ok && (ctx_loc == LOC_THR)) begin
                thresh_q[ctx_idx] <= wdata_q[PRI_W-1:0];
              end else if (ctx_ok && (ctx_loc == LOC_CLAIM) &&
                           (wdata_q[DATA_W-1:PEND_IW] == '0)) begin
                pending_q[wdata_q[PEND_IW-1:0]] <= 1'b0;
              end
            end
            ACT_RAISE: begin
              if (src_ok) begin
                pending_q[src_q] <= 1'b1;
              end
            end
            ACT_LOWER: begin
              if (src_ok) begin
                pending_q[src_q] <= 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
        S_PRI_RD: begin
          state_q <= S_PRI_DATA;
        end
        S_PRI_DATA: begin
          rdata_q <= DATA_W'(pri_rd);
          state_q <= S_IRQ0_START;
        end
        S_CLAIM_START: begin
          state_q <= S_CLAIM_WAIT;
        end
        S_CLAIM_WAIT: begin
          if (scan_sts.done) begin
            rdata_q <= DATA_W'(scan_sts.best);
            if (scan_sts.best != '0) begin
              pending_q[PEND_IW'(scan_sts.best)] <= 1'b0;
            end
            state_q <= S_IRQ0_START;
          end
        end
        S_IRQ0_START: begin
          scan_ctx_q <= '0;
          state_q    <= S_IRQ0_WAIT;
        end
        S_IRQ0_WAIT: begin
          if (scan_sts.done) begin
            irq0_q <= (scan_sts.best != '0);
            irq1_q <= 1'b0;
            state_q <= (NUM_CTX > 1) ? S_IRQ1_START : S_OUT;
          end
        end
        S_IRQ1_START: begin
          scan_ctx_q <= CTX_W'(NUM_CTX - 1);
          state_q    <= S_IRQ1_WAIT;
        end
        S_IRQ1_WAIT: begin
          if (scan_sts.done) begin
            irq1_q  <= (scan_sts.best != '0);
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_vld_q   <= 1'b1;
            out_rdata_q <= rdata_q;
            out_irq0_q  <= irq0_q;
            out_irq1_q  <= irq1_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_vld_q;
  assign read_data_o      = out_rdata_q;
  assign machine_irq_o    = out_irq0_q;
  assign supervisor_irq_o = out_irq1_q;

  // Scan results only come back while the sequencer waits for one
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_sts.done |-> (state_q == S_CLAIM_WAIT || state_q == S_IRQ0_WAIT ||
                       state_q == S_IRQ1_WAIT))
    else $error("scan done outside a wait state");

  // A claimed source must be pending when it is handed out
  a_claim_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLAIM_WAIT && scan_sts.done && scan_sts.best != '0) |->
      pending_q[PEND_IW'(scan_sts.best)])
    else $error("claimed source not pending");

  // An accepted item always starts with decode
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_DECODE))
    else $error("accepted item did not enter decode");

endmodule
